FILE: rtl/core/baro_pkg.sv
// Package for the barometric altitude and speed estimator.
// Holds the register indexes, field widths and range limits; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package baro_pkg;
	localparam int unsigned CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REF_PRESSURE = 3'd0,
		REG_ALPHA_ALT    = 3'd1,
		REG_ALPHA_SPD    = 3'd2,
		REG_TEMP_GAIN    = 3'd3,
		REG_TEMP_OFFSET  = 3'd4
	} cfg_reg_t;
	localparam logic signed [24:0] ALT_MIN = -25'sd1000000;
	localparam logic signed [24:0] ALT_MAX = 25'sd10000000;
	localparam logic signed [17:0] SPD_MIN = -18'sd100000;
	localparam logic signed [17:0] SPD_MAX = 18'sd100000;
	localparam logic [22:0] ALT_SCALE = 23'd4433000;
endpackage
`default_nettype wire

FILE: rtl/core/baro_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing beyond its clock and reset.
`timescale 1ns / 1ps
`default_nettype none
module baro_div #(
	parameter int unsigned NW = 48,
	parameter int unsigned DW = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NW-1:0]     num,
	input  wire logic [DW-1:0]     den,
	output logic                   busy,
	output logic [NW-1:0]          quo
);
	localparam int unsigned CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff = shifted - {1'b0, den_q};
	assign busy = (cnt_q != '0);
	assign quo = quo_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/baro_altitude_speed_estimator_top.sv
// Top level of the barometric altitude and speed estimator.
// Depends on baro_pkg and baro_div.
//
// Channel   Direction  Contents
// s_axis    in         tdata: pressure_a, pressure_b, pressure_c, temperature_raw, time_ms
// m_axis    out        tdata: pressure_median, temperature, altitude_cm, speed_cm_s,
//                      apogee_cm, max_speed_cm_s
// cfg       in         wr_en, wr_idx, wr_data
//
// One item at a time. Each item goes through a bit-serial division for the pressure
// ratio, then table interpolation, altitude, the altitude filter, a second bit-serial
// division for the speed and the speed filter; both divisions have 48-bit numerators.
// A new input is taken only in idle and once the result register is free.
// Reset returns the state machine, filter state and configuration registers to their
// reset values. The result register holds while m_axis_tready is low.
`timescale 1ns / 1ps
`default_nettype none
module baro_altitude_speed_estimator_top #(
	parameter int unsigned POW_TABLE_ENTRIES = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata, // pa, pb, pc, temperature_raw, time_ms, pad
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [119:0] m_axis_tdata, // median, temperature, altitude, speed, apogee, max speed
	input  wire logic         wr_en,
	input  wire logic [baro_pkg::CFG_IDX_W-1:0] wr_idx,
	input  wire logic [16:0]  wr_data
);
	import baro_pkg::*;
	localparam int unsigned LN = $clog2(POW_TABLE_ENTRIES);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RDIV  = 9'b000000010,
		ST_RWAIT = 9'b000000100,
		ST_INTP  = 9'b000001000,
		ST_ALT   = 9'b000010000,
		ST_EMA   = 9'b000100000,
		ST_SDIV  = 9'b001000000,
		ST_SWAIT = 9'b010000000,
		ST_SEMA  = 9'b100000000
	} state_t;
	state_t st_q;

	logic [16:0] ref_q;
	logic [15:0] aa_q, as_q;
	logic signed [15:0] gain_q;
	logic signed [14:0] off_q;
	logic signed [24:0] falt_q, palt_q;
	logic signed [17:0] fspd_q, pspd_q;
	logic [31:0] last_q;

	logic [16:0] pm_q;
	logic signed [15:0] temp_q;
	logic [31:0] dt_q;
	logic [16:0] ratio_q;
	logic [16:0] pw_q;
	logic signed [24:0] araw_q;
	logic signed [24:0] anew_q;
	logic signed [35:0] dalt_q;
	logic signed [47:0] spd_raw_q;
	logic out_valid_q;

	// Power table as a function, evaluated at elaboration.
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r, b, x;
		r = 0; b = 64'd1 << 62; x = v;
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b); r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction
	function automatic logic [63:0] log2q(input logic [63:0] n);
		logic [63:0] m, res;
		int e;
		e = 0;
		for (int i = 0; i < 40; i++) if ((n >> (e + 1)) != 0) e = e + 1;
		m = (n << 31) >> e;
		res = 64'(e) << 32;
		for (int b = 31; b >= 0; b--) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1; res = res | (64'd1 << b);
			end
		end
		return res;
	endfunction
	function automatic logic [63:0] exp2f(input logic [63:0] f);
		logic [63:0] r, rt;
		r = 64'd1 << 30;
		rt = isqrt64(64'd2 << 60);
		for (int k = 1; k <= 24; k++) begin
			if (k > 1) rt = isqrt64(rt << 30);
			if (f[32-k]) r = (r * rt) >> 30;
		end
		return r;
	endfunction
	function automatic logic [16:0] pow_entry(input int i);
		logic [63:0] la, lb, mag, y, q, fr, f, v;
		if (i == 0) return 17'd0;
		lb = log2q(64'(POW_TABLE_ENTRIES));
		la = log2q(64'(2 * i));
		mag = (la < lb) ? lb - la : la - lb;
		y = ((mag >> 4) * 64'd817332276) >> 28;
		q = y >> 32;
		if (la >= lb) begin
			if (q > 2) q = 2;
			v = (exp2f(y & 64'hFFFFFFFF) << q) >> 14;
		end else begin
			fr = y & 64'hFFFFFFFF; f = 0;
			if (fr != 0) begin
				q = q + 1; f = (64'd1 << 32) - fr;
			end
			v = (14 + q < 64) ? (exp2f(f) >> (14 + q)) : 64'd0;
		end
		return v[16:0];
	endfunction
	localparam int unsigned TN = POW_TABLE_ENTRIES + 1;
	function automatic logic [TN*17-1:0] build_tab();
		logic [TN*17-1:0] t;
		for (int i = 0; i < TN; i++) t[i*17 +: 17] = pow_entry(i);
		return t;
	endfunction
	localparam logic [TN*17-1:0] POW_TAB = build_tab();

	logic [16:0] pa, pb, pc, med;
	logic signed [14:0] traw;
	logic [31:0] now;
	assign pa = s_axis_tdata[16:0];
	assign pb = s_axis_tdata[33:17];
	assign pc = s_axis_tdata[50:34];
	assign traw = s_axis_tdata[65:51];
	assign now = s_axis_tdata[97:66];
	always_comb begin
		logic [16:0] lo, hi;
		lo = (pa < pb) ? pa : pb;
		hi = (pa < pb) ? pb : pa;
		if (pc <= lo) med = lo;
		else if (pc >= hi) med = hi;
		else med = pc;
	end
	logic signed [30:0] tprod;
	logic signed [22:0] tsh;
	logic signed [23:0] tsum;
	assign tprod = traw * gain_q;
	assign tsh = 23'(tprod >>> 8);
	assign tsum = 24'(tsh) + 24'(off_q);

	// Shared divider.
	logic div_start, div_busy;
	logic [47:0] dnum, dquo;
	logic [31:0] dden;
	baro_div #(.NW(48), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(dnum), .den(dden),
		.busy(div_busy), .quo(dquo)
	);
	logic [35:0] dmag;
	assign dmag = dalt_q[35] ? 36'(-dalt_q) : 36'(dalt_q);
	always_comb begin
		div_start = 1'b0;
		dnum = {15'd0, pm_q, 16'd0};
		dden = {15'd0, ref_q};
		if (st_q == ST_RDIV) div_start = 1'b1;
		if (st_q == ST_SDIV) begin
			div_start = 1'b1;
			dnum = {12'd0, dmag};
			dden = dt_q;
		end
	end

	logic [LN+16:0] pos;
	logic [LN-1:0] idx;
	logic [16:0] frac, t0, t1;
	logic signed [17:0] tdiff;
	logic signed [35:0] tmul;
	assign pos = {{LN{1'b0}}, ratio_q} * (LN+17)'(POW_TABLE_ENTRIES);
	assign idx = pos[LN+16:17];
	assign frac = pos[16:0];
	assign t0 = POW_TAB[idx*17 +: 17];
	assign t1 = POW_TAB[(idx+1)*17 +: 17];
	assign tdiff = $signed({1'b0, t1}) - $signed({1'b0, t0});
	assign tmul = tdiff * $signed({1'b0, frac});

	logic signed [17:0] omp;
	logic signed [41:0] aprod;
	assign omp = 18'sd65536 - $signed({1'b0, pw_q});
	assign aprod = omp * $signed({1'b0, ALT_SCALE});

	logic signed [43:0] ema_a;
	logic signed [41:0] ema_a_sh;
	assign ema_a = $signed({1'b0, aa_q}) * falt_q
		+ $signed(18'sd65536 - $signed({2'b0, aa_q})) * araw_q;
	assign ema_a_sh = 42'(ema_a >>> 16);

	logic signed [47:0] sq;
	logic signed [67:0] ema_s;
	logic signed [51:0] ema_s_sh;
	assign sq = dalt_q[35] ? -$signed(dquo) : $signed(dquo);
	assign ema_s = $signed({1'b0, as_q}) * fspd_q
		+ $signed(18'sd65536 - $signed({2'b0, as_q})) * spd_raw_q;
	assign ema_s_sh = 52'(ema_s >>> 16);

	assign s_axis_tready = (st_q == ST_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, pspd_q, palt_q, fspd_q, falt_q, temp_q, pm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= 17'd101325;
			aa_q <= 16'd52429;
			as_q <= 16'd52429;
			gain_q <= 16'sd256;
			off_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_REF_PRESSURE: ref_q <= wr_data;
				REG_ALPHA_ALT:    aa_q <= wr_data[15:0];
				REG_ALPHA_SPD:    as_q <= wr_data[15:0];
				REG_TEMP_GAIN:    gain_q <= wr_data[15:0];
				REG_TEMP_OFFSET:  off_q <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			falt_q <= '0; fspd_q <= '0; palt_q <= '0; pspd_q <= '0; last_q <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					st_q <= ST_RDIV;
					last_q <= now;
				end
				ST_RDIV: st_q <= ST_RWAIT;
				ST_RWAIT: if (!div_busy) st_q <= ST_INTP;
				ST_INTP: st_q <= ST_ALT;
				ST_ALT: st_q <= ST_EMA;
				ST_EMA: st_q <= ST_SDIV;
				ST_SDIV: begin
					st_q <= ST_SWAIT;
					falt_q <= anew_q;
					if (palt_q < anew_q) palt_q <= anew_q;
				end
				ST_SWAIT: if (!div_busy) st_q <= ST_SEMA;
				ST_SEMA: begin
					st_q <= ST_IDLE;
					out_valid_q <= 1'b1;
					if (ema_s_sh < 52'(SPD_MIN)) begin
						fspd_q <= SPD_MIN;
						if (pspd_q < SPD_MIN) pspd_q <= SPD_MIN;
					end else if (ema_s_sh > 52'(SPD_MAX)) begin
						fspd_q <= SPD_MAX;
						if (pspd_q < SPD_MAX) pspd_q <= SPD_MAX;
					end else begin
						fspd_q <= 18'(ema_s_sh);
						if (pspd_q < 18'(ema_s_sh)) pspd_q <= 18'(ema_s_sh);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				pm_q <= med;
				if (tsum > 24'sd32767) temp_q <= 16'sh7FFF;
				else if (tsum < -24'sd32768) temp_q <= 16'sh8000;
				else temp_q <= 16'(tsum);
				dt_q <= ((now - last_q) == 32'd0) ? 32'd1 : now - last_q;
			end
			ST_RWAIT: begin
				if (ref_q == 17'd0 || dquo > 48'd131071) ratio_q <= 17'd131071;
				else ratio_q <= dquo[16:0];
			end
			ST_INTP: pw_q <= 17'($signed({1'b0, t0}) + 36'(tmul >>> 17));
			ST_ALT: araw_q <= 25'(aprod >>> 16);
			ST_EMA: begin
				if (ema_a_sh < 42'(ALT_MIN)) anew_q <= ALT_MIN;
				else if (ema_a_sh > 42'(ALT_MAX)) anew_q <= ALT_MAX;
				else anew_q <= 25'(ema_a_sh);
			end
			ST_SDIV: ;
			ST_SWAIT: spd_raw_q <= sq;
			default: ;
		endcase
		if (st_q == ST_EMA) begin
			if (ema_a_sh < 42'(ALT_MIN)) dalt_q <= (36'(ALT_MIN) - 36'(falt_q)) * 36'sd1000;
			else if (ema_a_sh > 42'(ALT_MAX)) dalt_q <= (36'(ALT_MAX) - 36'(falt_q)) * 36'sd1000;
			else dalt_q <= (36'(ema_a_sh) - 36'(falt_q)) * 36'sd1000;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
	a_spd_range: assert property (@(posedge clk) disable iff (!arst_n)
		fspd_q >= SPD_MIN && fspd_q <= SPD_MAX) else $error("speed out of range");
endmodule
`default_nettype wire
